// ===== rtl/core/scipdec_pkg.sv =====
// scipdec_pkg: shared types and constants for the six-bit range stream decoder
// no dependencies; used by rtl/core/scip_range_stream_decoder.sv
package scipdec_pkg;

  localparam int CHAR_W   = 8;
  localparam int DIGIT_W  = 6;
  localparam int VALUE_W  = 24;
  localparam int INDEX_W  = 11;
  localparam int CPV_W    = 3;
  localparam int REPS_W   = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CHAR_W-1:0]  CHAR_BIAS = 8'h30;
  localparam logic [DIGIT_W-1:0] DIGIT_BIAS = 6'h30;

  localparam logic [CPV_W-1:0]  CPV_MIN  = 3'd2;
  localparam logic [CPV_W-1:0]  CPV_MAX  = 3'd4;
  localparam logic [CPV_W-1:0]  CPV_RST  = 3'd3;
  localparam logic [REPS_W-1:0] REPS_MIN = 7'd1;
  localparam logic [REPS_W-1:0] REPS_MAX = 7'd64;
  localparam logic [REPS_W-1:0] REPS_RST = 7'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHARS_PER_VALUE = 1'b0,
    CFG_CLUSTER_COUNT   = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    KIND_RANGE    = 1'b0,
    KIND_CHECKSUM = 1'b1
  } kind_t;

  // decoder state carried between characters
  typedef struct packed {
    logic [VALUE_W-1:0] partial_value;
    logic [1:0]         digit_count;
    logic [DIGIT_W-1:0] line_sum;
    logic [INDEX_W-1:0] sample_count;
    logic               overflow_seen;
  } dec_state_t;

endpackage

// ===== rtl/core/scip_range_stream_decoder.sv =====
// scip_range_stream_decoder: six-bit character decoder for rangefinder scan data
// depends on rtl/core/scipdec_pkg.sv
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  in_     | input     | in_valid/in_stall  | char_code, is_checksum, scan_start
//  out_    | output    | out_valid/out_stall| kind, range_value, sample_index, checksum_ok,
//          |           |                    | index_overflow, last_of_run
//  cfg_    | input     | cfg_wr_en          | cfg_index, cfg_wdata
//
// one character is taken per cycle unless stalled; its first result is registered next cycle
// a completed value with cluster count n occupies the output register for n beats, and the
// input is held (in_stall high) until the last copy is loaded
// rst_n is synchronous: clears decoder state, the output valid and loads register defaults
// in_stall: a beat is taken with no copies pending and the output register empty or draining

module scip_range_stream_decoder #(
  parameter int MAX_SAMPLES = 2048
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [scipdec_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scipdec_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [scipdec_pkg::CHAR_W-1:0]       in_char_code,
  input  logic                                 in_is_checksum,
  input  logic                                 in_scan_start,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_kind,
  output logic [scipdec_pkg::VALUE_W-1:0]      out_range_value,
  output logic [scipdec_pkg::INDEX_W-1:0]      out_sample_index,
  output logic                                 out_checksum_ok,
  output logic                                 out_index_overflow,
  output logic                                 out_last_of_run
);

  localparam int TOP_LIM = (MAX_SAMPLES > 2048) ? 2048 : MAX_SAMPLES;
  localparam logic [scipdec_pkg::INDEX_W-1:0] TOP_INDEX =
    scipdec_pkg::INDEX_W'(TOP_LIM - 1);

  logic [scipdec_pkg::CPV_W-1:0]  cpv_r;
  logic [scipdec_pkg::REPS_W-1:0] reps_r;

  scipdec_pkg::dec_state_t st_r, st_nxt, st_base;

  logic [scipdec_pkg::REPS_W-1:0] rep_left_r, rep_left_nxt;

  logic                             out_valid_r, out_valid_nxt;
  scipdec_pkg::kind_t               out_kind_r, out_kind_nxt;
  logic [scipdec_pkg::VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic [scipdec_pkg::INDEX_W-1:0]  out_index_r, out_index_nxt;
  logic                             out_ok_r, out_ok_nxt;
  logic                             out_ovf_r, out_ovf_nxt;
  logic                             out_last_r, out_last_nxt;

  logic in_accept, out_take, rep_step;
  logic [scipdec_pkg::CPV_W-1:0]   cpv_c;
  logic [scipdec_pkg::REPS_W-1:0]  reps_c;
  logic [scipdec_pkg::DIGIT_W-1:0] digit;
  logic [scipdec_pkg::VALUE_W-1:0] shifted;
  logic [2:0]                      n_digits;
  logic [scipdec_pkg::CHAR_W-1:0]  expect_char;
  logic [scipdec_pkg::INDEX_W-1:0] copy_index;
  logic                            copy_ovf;
  logic [scipdec_pkg::INDEX_W-1:0] copy_index_nxt;
  logic                            copy_ovf_nxt;

  assign out_take  = out_valid_r && !out_stall;
  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (rep_left_r != '0) || (out_valid_r && out_stall);
  assign rep_step  = out_take && (rep_left_r != '0);

  always_comb begin
    if (cpv_r < scipdec_pkg::CPV_MIN) begin
      cpv_c = scipdec_pkg::CPV_MIN;
    end else if (cpv_r > scipdec_pkg::CPV_MAX) begin
      cpv_c = scipdec_pkg::CPV_MAX;
    end else begin
      cpv_c = cpv_r;
    end
    if (reps_r < scipdec_pkg::REPS_MIN) begin
      reps_c = scipdec_pkg::REPS_MIN;
    end else if (reps_r > scipdec_pkg::REPS_MAX) begin
      reps_c = scipdec_pkg::REPS_MAX;
    end else begin
      reps_c = reps_r;
    end
  end

  // scan start clears state before the beat is taken
  always_comb begin
    if (in_scan_start) begin
      st_base = '0;
    end else begin
      st_base = st_r;
    end
  end

  assign digit       = in_char_code[scipdec_pkg::DIGIT_W-1:0] - scipdec_pkg::DIGIT_BIAS;
  assign shifted     = {st_base.partial_value[scipdec_pkg::VALUE_W-scipdec_pkg::DIGIT_W-1:0],
                        digit};
  assign n_digits    = {1'b0, st_base.digit_count} + 3'd1;
  assign expect_char = {2'b00, st_base.line_sum} + scipdec_pkg::CHAR_BIAS;

  // index of the copy about to be loaded, and what follows it
  always_comb begin
    if (in_accept) begin
      copy_index = st_base.sample_count;
      copy_ovf   = st_base.overflow_seen;
    end else begin
      copy_index = st_r.sample_count;
      copy_ovf   = st_r.overflow_seen;
    end
    if (copy_index < TOP_INDEX) begin
      copy_index_nxt = copy_index + 11'd1;
      copy_ovf_nxt   = copy_ovf;
    end else begin
      copy_index_nxt = copy_index;
      copy_ovf_nxt   = 1'b1;
    end
  end

  always_comb begin
    st_nxt        = st_r;
    rep_left_nxt  = rep_left_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_index_nxt = out_index_r;
    out_ok_nxt    = out_ok_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;

    if (out_take) begin
      out_valid_nxt = 1'b0;
    end

    if (in_accept) begin
      st_nxt = st_base;
      if (in_is_checksum) begin
        st_nxt.line_sum = '0;
        out_valid_nxt   = 1'b1;
        out_kind_nxt    = scipdec_pkg::KIND_CHECKSUM;
        out_value_nxt   = '0;
        out_index_nxt   = st_base.sample_count;
        out_ok_nxt      = (in_char_code == expect_char);
        out_ovf_nxt     = st_base.overflow_seen;
        out_last_nxt    = 1'b1;
        rep_left_nxt    = '0;
      end else begin
        st_nxt.line_sum = st_base.line_sum + in_char_code[scipdec_pkg::DIGIT_W-1:0];
        if (n_digits < cpv_c) begin
          st_nxt.partial_value = shifted;
          st_nxt.digit_count   = n_digits[1:0];
        end else begin
          st_nxt.partial_value = '0;
          st_nxt.digit_count   = '0;
          st_nxt.sample_count  = copy_index_nxt;
          st_nxt.overflow_seen = copy_ovf_nxt;
          out_valid_nxt        = 1'b1;
          out_kind_nxt         = scipdec_pkg::KIND_RANGE;
          out_value_nxt        = (cpv_c == scipdec_pkg::CPV_MAX) ? shifted
                                                               : {8'h00, shifted[15:0]};
          out_index_nxt        = copy_index;
          out_ok_nxt           = 1'b0;
          out_ovf_nxt          = copy_ovf;
          out_last_nxt         = (reps_c == scipdec_pkg::REPS_MIN);
          rep_left_nxt         = reps_c - scipdec_pkg::REPS_MIN;
        end
      end
    end else if (rep_step) begin
      // next copy of the held value
      st_nxt.sample_count  = copy_index_nxt;
      st_nxt.overflow_seen = copy_ovf_nxt;
      out_valid_nxt        = 1'b1;
      out_index_nxt        = copy_index;
      out_ovf_nxt          = copy_ovf;
      out_last_nxt         = (rep_left_r == scipdec_pkg::REPS_MIN);
      rep_left_nxt         = rep_left_r - scipdec_pkg::REPS_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpv_r       <= scipdec_pkg::CPV_RST;
      reps_r      <= scipdec_pkg::REPS_RST;
      st_r        <= '0;
      rep_left_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (scipdec_pkg::cfg_idx_t'(cfg_index))
          scipdec_pkg::CFG_CHARS_PER_VALUE: cpv_r  <= cfg_wdata[scipdec_pkg::CPV_W-1:0];
          scipdec_pkg::CFG_CLUSTER_COUNT:   reps_r <= cfg_wdata;
          default: ;
        endcase
      end
      st_r        <= st_nxt;
      rep_left_r  <= rep_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_index_r <= out_index_nxt;
    out_ok_r    <= out_ok_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_range_value    = out_value_r;
  assign out_sample_index   = out_index_r;
  assign out_checksum_ok    = out_ok_r;
  assign out_index_overflow = out_ovf_r;
  assign out_last_of_run    = out_last_r;

  // pending copies always sit behind a shown, non-final copy
  a_rep_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (rep_left_r != '0) |-> (out_valid_r && !out_last_r))
    else $error("copies pending without a shown non-final copy");

  a_ovf_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovf_r) |-> (out_index_r == TOP_INDEX))
    else $error("overflow flagged below top index");

  a_cksum_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == scipdec_pkg::KIND_CHECKSUM)
      |-> (out_last_r && out_value_r == '0))
    else $error("checksum result with value or not last");

  a_range_no_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == scipdec_pkg::KIND_RANGE) |-> !out_ok_r)
    else $error("range result with checksum flag");

  a_copy_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (rep_step && !out_ovf_r && out_index_r != TOP_INDEX)
      |=> (out_index_r == $past(out_index_r) + 11'd1))
    else $error("repeated copy index did not advance");

endmodule
